>>> rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Types, codes and constants shared by the sorted source table files.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int POS_W        = 11;
    localparam logic [15:0] METRIC_INF  = 16'hFFFF;
    localparam logic [15:0] REFS_MAX    = 16'hFFFF;
    localparam logic [15:0] GC_TIME_RST = 16'd200;

    typedef enum logic [2:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_CREATE  = 3'd1,
        CMD_UPDATE  = 3'd2,
        CMD_RETAIN  = 3'd3,
        CMD_RELEASE = 3'd4,
        CMD_EXPIRE  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CREATED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_COUNT_ERR = 3'd4,
        ST_IGNORED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_SORT,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_WRITE,
        OP_EXPIRE,
        OP_SORT
    } t_cell_op;

    typedef struct packed {
        logic [63:0] node_id;
        logic [7:0]  prefix_len;
        logic [63:0] prefix_high;
        logic [63:0] prefix_low;
        logic [63:0] from_high;
        logic [63:0] from_low;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [7:0]  from_len;
        logic [15:0] seq;
        logic [15:0] metric;
        logic [31:0] stamp;
        logic [15:0] refs;
    } t_entry;

    typedef struct packed {
        t_cell_op         op;
        t_entry           ent;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] count;
        logic             parity;
        logic [31:0]      now;
        logic [15:0]      gc;
    } t_cell_ctrl;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] count;
        logic             found;
        logic [15:0]      seq;
        logic [15:0]      metric;
        logic [31:0]      stamp;
        logic [15:0]      refs;
    } t_scan;

endpackage

>>> rtl/sst_in_if.sv
// ----------------------------------------------------------------------------
// sst_in_if
// Command channel: valid/ready with one command word.
// ----------------------------------------------------------------------------
interface sst_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] node_id;
    logic [7:0]  prefix_len;
    logic [63:0] prefix_high;
    logic [63:0] prefix_low;
    logic [63:0] from_prefix_high;
    logic [63:0] from_prefix_low;
    logic [7:0]  from_prefix_len;
    logic [15:0] seq_number;
    logic [15:0] route_metric;
    logic [31:0] now_seconds;

    modport source (output valid, cmd, node_id, prefix_len, prefix_high, prefix_low,
                    from_prefix_high, from_prefix_low, from_prefix_len, seq_number,
                    route_metric, now_seconds, input ready);
    modport sink (input valid, cmd, node_id, prefix_len, prefix_high, prefix_low,
                  from_prefix_high, from_prefix_low, from_prefix_len, seq_number,
                  route_metric, now_seconds, output ready);
endinterface

>>> rtl/sst_out_if.sv
// ----------------------------------------------------------------------------
// sst_out_if
// Result channel: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface sst_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] seq_out;
    logic [15:0] metric_out;
    logic [15:0] ref_count;
    logic [6:0]  entry_total;

    modport source (output valid, status, slot_index, seq_out, metric_out, ref_count,
                    entry_total, input ready);
    modport sink (input valid, status, slot_index, seq_out, metric_out, ref_count,
                  entry_total, output ready);
endinterface

>>> rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell
// One table slot: holds an entry, swaps with neighbors, and adds its part to
// the search word that ripples down the row.
// ----------------------------------------------------------------------------
module sst_cell import sst_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_key       i_key,
    input  t_entry     i_left_ent,
    input  logic       i_left_valid,
    input  t_entry     i_right_ent,
    input  logic       i_right_valid,
    input  t_scan      i_scan,
    output t_entry     o_ent,
    output logic       o_valid,
    output t_scan      o_scan
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);
    localparam logic             IS_ODD = 1'(IDX % 2);

    t_entry r_ent, n_ent;
    logic   r_valid, n_valid;
    t_scan  r_scan, n_scan;
    logic   w_lt, w_eq, w_stale;
    logic [31:0] w_clamp;

    assign w_lt = r_valid && (r_ent.key < i_key);
    assign w_eq = r_valid && (r_ent.key == i_key);
    assign w_clamp = (r_ent.stamp > i_ctrl.now) ? i_ctrl.now : r_ent.stamp;
    assign w_stale = ({1'b0, w_clamp} + {17'b0, i_ctrl.gc}) < {1'b0, i_ctrl.now};

    always_comb begin
        n_ent   = r_ent;
        n_valid = r_valid;
        unique case (i_ctrl.op)
            OP_INSERT: begin
                if (MY_POS == i_ctrl.pos) begin
                    n_ent   = i_ctrl.ent;
                    n_valid = 1'b1;
                end else if (MY_POS > i_ctrl.pos && MY_POS <= i_ctrl.count) begin
                    n_ent   = i_left_ent;
                    n_valid = 1'b1;
                end
            end
            OP_WRITE: begin
                if (MY_POS == i_ctrl.pos) begin
                    n_ent.seq    = i_ctrl.ent.seq;
                    n_ent.metric = i_ctrl.ent.metric;
                    n_ent.stamp  = i_ctrl.ent.stamp;
                    n_ent.refs   = i_ctrl.ent.refs;
                end
            end
            OP_EXPIRE: begin
                if (r_valid) begin
                    n_ent.stamp = w_clamp;
                    n_valid     = !(r_ent.refs == 16'd0 && w_stale);
                end
            end
            OP_SORT: begin
                if (IS_ODD == i_ctrl.parity) begin
                    if (!r_valid && i_right_valid) begin
                        n_ent   = i_right_ent;
                        n_valid = 1'b1;
                    end
                end else if (!i_left_valid && r_valid) begin
                    n_ent   = i_left_ent;
                    n_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_scan = i_scan;
        if (r_valid) begin
            n_scan.count = i_scan.count + POS_W'(1);
        end
        if (w_lt) begin
            n_scan.pos = i_scan.pos + POS_W'(1);
        end
        if (w_eq) begin
            n_scan.found  = 1'b1;
            n_scan.seq    = r_ent.seq;
            n_scan.metric = r_ent.metric;
            n_scan.stamp  = r_ent.stamp;
            n_scan.refs   = r_ent.refs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_ent  <= n_ent;
        r_scan <= n_scan;
    end

    assign o_ent   = r_ent;
    assign o_valid = r_valid;
    assign o_scan  = r_scan;

endmodule

>>> rtl/sorted_source_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_source_table_unit
// Sorted table of routing sources held in a row of slot cells.
// ----------------------------------------------------------------------------
// Commands arrive on i_in (valid/ready), one result word per command leaves
// on o_out (valid/ready). gc_time is written through i_cfg_we/i_cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// One command is in flight at a time; i_in.ready is high only when the
// sequencer is idle. Lookup, create, update, retain and release run a
// search pass, then execute: the search word ripples one cell per cycle
// down the row of CAPACITY cells. Expire first sweeps out stale entries
// with no references, then CAPACITY odd/even swap phases compact the row,
// then one ripple pass counts the entries left.
// Unknown commands skip the search and go straight to the result.
// A finished result sits in the output register until taken; a new command
// may be accepted meanwhile, and its result waits for the register to drain.
// Reset empties the table and sets gc_time to 200; no clearing pass runs.
// ----------------------------------------------------------------------------
module sorted_source_table_unit import sst_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    sst_in_if.sink        i_in,
    sst_out_if.source     o_out
);

    localparam int SW = $clog2(CAPACITY);

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [15:0] seq;
        logic [15:0] metric;
        logic [15:0] refs;
        logic [6:0]  total;
    } t_res;

    t_state r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic [POS_W-1:0] r_count, n_count;
    logic [15:0] r_gc;
    logic r_swept, n_swept;
    logic [2:0] r_cmd;
    t_key r_key;
    logic [7:0] r_flen;
    logic [15:0] r_seq, r_metric;
    logic [31:0] r_now;
    t_res r_res, n_res;
    logic w_res_load;
    t_res r_out;
    logic r_out_valid;
    logic w_in_acc, w_out_load;

    t_cell_ctrl w_ctrl;
    t_entry w_ent [CAPACITY];
    logic   w_valid [CAPACITY];
    t_scan  w_scan [CAPACITY];
    t_scan  w_last;
    logic [15:0] w_diff;
    logic w_newer, w_stale, w_take;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_last     = w_scan[CAPACITY-1];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_entry w_l_ent, w_r_ent;
            logic   w_l_valid, w_r_valid;
            t_scan  w_s_in;
            if (gi == 0) begin : g_first
                assign w_l_ent   = '0;
                assign w_l_valid = 1'b1;
                assign w_s_in    = '0;
            end else begin : g_mid
                assign w_l_ent   = w_ent[gi-1];
                assign w_l_valid = w_valid[gi-1];
                assign w_s_in    = w_scan[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_r_ent   = '0;
                assign w_r_valid = 1'b0;
            end else begin : g_inner
                assign w_r_ent   = w_ent[gi+1];
                assign w_r_valid = w_valid[gi+1];
            end
            sst_cell #(.IDX(gi)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_key        (r_key),
                .i_left_ent   (w_l_ent),
                .i_left_valid (w_l_valid),
                .i_right_ent  (w_r_ent),
                .i_right_valid(w_r_valid),
                .i_scan       (w_s_in),
                .o_ent        (w_ent[gi]),
                .o_valid      (w_valid[gi]),
                .o_scan       (w_scan[gi])
            );
        end
    endgenerate

    assign w_diff  = r_seq - w_last.seq;
    assign w_newer = (w_diff != 16'd0) && !w_diff[15];
    assign w_stale = ({1'b0, w_last.stamp} + {17'b0, r_gc}) < {1'b0, r_now};
    assign w_take  = w_stale || w_newer || (w_last.seq == r_seq && w_last.metric > r_metric);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_count    = r_count;
        n_swept    = r_swept;
        w_res_load = 1'b0;
        w_out_load = 1'b0;
        n_res      = '{status: ST_OK, slot: '0, seq: '0, metric: '0, refs: '0,
                       total: r_count[6:0]};

        w_ctrl.op         = OP_HOLD;
        w_ctrl.ent.key    = r_key;
        w_ctrl.ent.from_len = r_flen;
        w_ctrl.ent.seq    = r_seq;
        w_ctrl.ent.metric = METRIC_INF;
        w_ctrl.ent.stamp  = r_now;
        w_ctrl.ent.refs   = '0;
        w_ctrl.pos        = w_last.pos;
        w_ctrl.count      = r_count;
        w_ctrl.parity     = r_step[0];
        w_ctrl.now        = r_now;
        w_ctrl.gc         = r_gc;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_swept = 1'b0;
                    n_step  = '0;
                    if (i_in.cmd == CMD_EXPIRE) begin
                        n_state = S_EXEC;
                    end else if (i_in.cmd > CMD_EXPIRE) begin
                        n_res.status = ST_IGNORED;
                        w_res_load   = 1'b1;
                        n_state      = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_step = r_step + SW'(1);
                if (r_step == SW'(CAPACITY - 1)) begin
                    n_step  = '0;
                    n_state = S_EXEC;
                end
            end
            S_SORT: begin
                w_ctrl.op = OP_SORT;
                n_step    = r_step + SW'(1);
                if (r_step == SW'(CAPACITY - 1)) begin
                    n_step  = '0;
                    n_state = S_SCAN;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                w_res_load = 1'b1;
                n_res.slot = w_last.pos[5:0];
                n_res.seq    = w_last.seq;
                n_res.metric = w_last.metric;
                n_res.refs   = w_last.refs;
                priority if (r_cmd == CMD_EXPIRE) begin
                    n_res.slot   = '0;
                    n_res.seq    = '0;
                    n_res.metric = '0;
                    n_res.refs   = '0;
                    if (!r_swept) begin
                        w_ctrl.op  = OP_EXPIRE;
                        n_swept    = 1'b1;
                        w_res_load = 1'b0;
                        n_state    = S_SORT;
                    end else begin
                        n_count     = w_last.count;
                        n_res.total = w_last.count[6:0];
                    end
                end else if (w_last.found) begin
                    w_ctrl.ent.seq    = w_last.seq;
                    w_ctrl.ent.metric = w_last.metric;
                    w_ctrl.ent.stamp  = w_last.stamp;
                    w_ctrl.ent.refs   = w_last.refs;
                    unique case (r_cmd)
                        CMD_UPDATE: begin
                            if (r_metric == METRIC_INF) begin
                                n_res.status = ST_IGNORED;
                            end else begin
                                w_ctrl.op = OP_WRITE;
                                w_ctrl.ent.stamp = r_now;
                                if (w_take) begin
                                    w_ctrl.ent.seq    = r_seq;
                                    w_ctrl.ent.metric = r_metric;
                                end
                                n_res.seq    = w_ctrl.ent.seq;
                                n_res.metric = w_ctrl.ent.metric;
                            end
                        end
                        CMD_RETAIN: begin
                            if (w_last.refs == REFS_MAX) begin
                                n_res.status = ST_COUNT_ERR;
                            end else begin
                                w_ctrl.op       = OP_WRITE;
                                w_ctrl.ent.refs = w_last.refs + 16'd1;
                                n_res.refs      = w_ctrl.ent.refs;
                            end
                        end
                        CMD_RELEASE: begin
                            if (w_last.refs == 16'd0) begin
                                n_res.status = ST_COUNT_ERR;
                            end else begin
                                w_ctrl.op       = OP_WRITE;
                                w_ctrl.ent.refs = w_last.refs - 16'd1;
                                n_res.refs      = w_ctrl.ent.refs;
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    n_res.slot   = '0;
                    n_res.seq    = '0;
                    n_res.metric = '0;
                    n_res.refs   = '0;
                    if (r_cmd != CMD_CREATE) begin
                        n_res.status = ST_NOT_FOUND;
                    end else if (r_count == POS_W'(CAPACITY)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        w_ctrl.op    = OP_INSERT;
                        n_count      = r_count + POS_W'(1);
                        n_res.status = ST_CREATED;
                        n_res.slot   = w_last.pos[5:0];
                        n_res.seq    = r_seq;
                        n_res.metric = METRIC_INF;
                        n_res.total  = n_count[6:0];
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_swept     <= 1'b0;
            r_gc        <= GC_TIME_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_count <= n_count;
            r_swept <= n_swept;
            if (i_cfg_we) begin
                r_gc <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd             <= i_in.cmd;
            r_key.node_id     <= i_in.node_id;
            r_key.prefix_len  <= i_in.prefix_len;
            r_key.prefix_high <= i_in.prefix_high;
            r_key.prefix_low  <= i_in.prefix_low;
            r_key.from_high   <= i_in.from_prefix_high;
            r_key.from_low    <= i_in.from_prefix_low;
            r_flen            <= i_in.from_prefix_len;
            r_seq             <= i_in.seq_number;
            r_metric          <= i_in.route_metric;
            r_now             <= i_in.now_seconds;
        end
        if (w_res_load) begin
            r_res <= n_res;
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.slot_index  = r_out.slot;
    assign o_out.seq_out     = r_out.seq;
    assign o_out.metric_out  = r_out.metric;
    assign o_out.ref_count   = r_out.refs;
    assign o_out.entry_total = r_out.total;

endmodule

>>> rtl/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the sorted source table, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker import sst_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [5:0]  i_slot,
    input logic [15:0] i_seq,
    input logic [15:0] i_metric,
    input logic [15:0] i_refs,
    input logic [6:0]  i_total
);

    localparam logic [6:0] CAP_TOTAL = 7'(CAPACITY);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command accepted while one is in flight");

    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_NOT_FOUND || i_status == ST_FULL)
        |-> (i_slot == 6'd0 && i_seq == 16'd0 && i_metric == 16'd0 && i_refs == 16'd0))
        else $error("entry fields set without an entry");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_total == CAP_TOTAL)
        else $error("table full reported below capacity");

    a_created_metric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_CREATED |-> (i_metric == METRIC_INF && i_refs == 16'd0))
        else $error("new entry not initialized");

endmodule

bind sorted_source_table_unit sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_status   (o_out.status),
    .i_slot     (o_out.slot_index),
    .i_seq      (o_out.seq_out),
    .i_metric   (o_out.metric_out),
    .i_refs     (o_out.ref_count),
    .i_total    (o_out.entry_total)
);
